/* design/ywr_pkg.sv */
// Shared types and constants for the planar 4:2:0 to packed 4:2:2 writer.
`default_nettype none
package ywr_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int PITCH_ALIGN  = 32;
	localparam int PITCH_SHIFT  = $clog2(PITCH_ALIGN);
	localparam int HEIGHT_LIMIT = 2048;

	localparam int DIM_W   = 12;
	localparam int GEO_W   = 14;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 11;
	localparam int ADDR_W  = 24;
	localparam int BYTE_W  = 8;
	localparam int STORE_DEPTH = 1 << COL_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [DIM_W-1:0]  WIDTH_RESET     = DIM_W'(720);
	localparam logic [DIM_W-1:0]  HEIGHT_RESET    = DIM_W'(576);
	localparam logic [ADDR_W-1:0] BASE_ADDR_RESET = '0;

	typedef enum logic [1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_BASE_ADDR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] luma_first;
		logic [BYTE_W-1:0] luma_second;
		logic [BYTE_W-1:0] chroma_red;
		logic [BYTE_W-1:0] chroma_blue;
	} in_item_t;

	typedef struct packed {
		logic [31:0]       packed_word;
		logic [ADDR_W-1:0] word_addr;
		logic              frame_end;
	} out_item_t;

	typedef struct packed {
		logic [DIM_W-1:0]  src_width;
		logic [DIM_W-1:0]  src_height;
		logic [ADDR_W-1:0] base_word_addr;
	} cfg_t;

	// One classified request between the front and the back.
	typedef struct packed {
		logic [BYTE_W-1:0] luma0;
		logic [BYTE_W-1:0] luma1;
		logic [BYTE_W-1:0] cr;
		logic [BYTE_W-1:0] cb;
		logic [COL_W-1:0]  slot;
		logic              odd_row;
		logic [ADDR_W-1:0] word_addr;
		logic              frame_end;
	} req_t;

endpackage
`default_nettype wire

/* design/ywr_front.sv */
// Front: accepts pixel groups, tracks raster position and computes addresses.
`default_nettype none
module ywr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ywr_pkg::in_item_t             in_data,
	input  ywr_pkg::cfg_t                 cfg,
	input  logic                          base_wr,
	input  logic [ywr_pkg::ADDR_W-1:0]    base_new,
	output logic                          push,
	output ywr_pkg::req_t                 push_data,
	input  logic                          q_full
);
	import ywr_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] line_start_q;

	logic [GEO_W-1:0] fw;
	logic [GEO_W-1:0] w_clamp;
	logic [GEO_W-1:0] w;
	logic [GEO_W-1:0] groups;
	logic [GEO_W-1:0] pitch;
	logic [GEO_W-1:0] line_words;
	logic [DIM_W-1:0] h_clamp;
	logic [DIM_W-1:0] h;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic             row_end;
	logic             frm_end;
	logic             accept;

	assign fw      = GEO_W'(cfg.src_width);
	assign w_clamp = (fw < GEO_W'(2)) ? GEO_W'(2) :
	                 (fw > GEO_W'(MAX_WIDTH)) ? GEO_W'(MAX_WIDTH) : fw;
	assign w       = {w_clamp[GEO_W-1:1], 1'b0};
	assign groups  = w >> 1;
	assign pitch   = ((w + GEO_W'(PITCH_ALIGN - 1)) >> PITCH_SHIFT) << PITCH_SHIFT;
	assign line_words = groups + ((pitch - w) >> 1);

	assign h_clamp = (cfg.src_height < DIM_W'(2)) ? DIM_W'(2) :
	                 (cfg.src_height > DIM_W'(HEIGHT_LIMIT)) ? DIM_W'(HEIGHT_LIMIT) :
	                 cfg.src_height;
	assign h       = {h_clamp[DIM_W-1:1], 1'b0};

	assign col_inc = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_inc = {1'b0, row_q} + (ROW_W+1)'(1);
	assign row_end = GEO_W'(col_inc) >= groups;
	assign frm_end = row_end && (DIM_W'(row_inc) >= h);

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept;

	always_comb begin
		push_data.luma0     = in_data.luma_first;
		push_data.luma1     = in_data.luma_second;
		push_data.cr        = in_data.chroma_red;
		push_data.cb        = in_data.chroma_blue;
		push_data.slot      = col_q;
		push_data.odd_row   = row_q[0];
		push_data.word_addr = line_start_q + ADDR_W'(col_q);
		push_data.frame_end = frm_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			line_start_q <= BASE_ADDR_RESET;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (frm_end) begin
					row_q        <= '0;
					line_start_q <= cfg.base_word_addr;
				end else begin
					row_q        <= row_inc[ROW_W-1:0];
					line_start_q <= line_start_q + ADDR_W'(line_words);
				end
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end else if (base_wr && col_q == '0 && row_q == '0) begin
			// new base applies at once only before the first group of a frame
			line_start_q <= base_new;
		end
	end

`ifndef NO_ASSERTIONS
	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frm_end |=> col_q == '0 && row_q == '0)
		else $error("counters not cleared after frame end");

	a_row_clears_col: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_end |=> col_q == '0)
		else $error("column not cleared at row end");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(col_q) && $stable(row_q))
		else $error("raster position moved without a request");
`endif

endmodule
`default_nettype wire

/* design/ywr_queue.sv */
// Short request queue between the front and the back.
`default_nettype none
module ywr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ywr_pkg::req_t  push_data,
	output logic           full,
	input  logic           pop,
	output ywr_pkg::req_t  head,
	output logic           empty
);
	import ywr_pkg::*;

	req_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* design/ywr_back.sv */
// Back: chroma line store, word packing and the output register.
`default_nettype none
module ywr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ywr_pkg::req_t      head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output ywr_pkg::out_item_t out_data
);
	import ywr_pkg::*;

	logic [2*BYTE_W-1:0] store [STORE_DEPTH];
	logic [2*BYTE_W-1:0] rdata_s1;
	req_t                req_s1;
	logic                valid_s1;
	logic                adv_s1;
	logic                out_valid_q;
	out_item_t           out_data_q;
	logic [BYTE_W-1:0]   cr_s1;
	logic [BYTE_W-1:0]   cb_s1;

	assign adv_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign pop    = !empty && (!valid_s1 || adv_s1);

	// even rows write the pair, odd rows read the pair of the row above
	always_ff @(posedge clk) begin
		if (pop && !head.odd_row)
			store[head.slot] <= {head.cb, head.cr};
		if (pop && head.odd_row)
			rdata_s1 <= store[head.slot];
		if (pop)
			req_s1 <= head;
		if (adv_s1)
			out_data_q <= '{packed_word: {cb_s1, req_s1.luma1, cr_s1, req_s1.luma0},
			                word_addr:   req_s1.word_addr,
			                frame_end:   req_s1.frame_end};
	end

	assign cr_s1 = req_s1.odd_row ? rdata_s1[BYTE_W-1:0] : req_s1.cr;
	assign cb_s1 = req_s1.odd_row ? rdata_s1[2*BYTE_W-1:BYTE_W] : req_s1.cb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

/* design/yuv420_to_packed_422_writer_core.sv */
// Top level: configuration registers and the front, queue and back parts.
`default_nettype none
// Packs a 4:2:0 raster stream of two-pixel groups into 32-bit 4:2:2 words
// (luma0, cr, luma1, cb from the low byte up) with their video memory word
// address; lines use a pitch rounded up to 32 pixels and odd rows take the
// chroma pair stored on the even row above. One group is accepted per clock
// and one word leaves per clock when the output is not stalled. A request
// goes through the front (position and address), a four-entry queue, the
// line store read stage and the output register, in that order; the
// single-port line store, read or written once per request, sets the
// one-per-cycle rate. Registers: frame width at 0x0, frame height at 0x4,
// base word address at 0x8; write them only while no request is in flight.
module yuv420_to_packed_422_writer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ywr_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ywr_pkg::out_item_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ywr_pkg::PADDR_W-1:0]   paddr,
	input  logic [ywr_pkg::PDATA_W-1:0]   pwdata,
	output logic [ywr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import ywr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;
	logic     base_wr;
	logic     push;
	req_t     push_data;
	logic     q_full;
	logic     pop;
	req_t     head;
	logic     empty;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign base_wr = wr_en && reg_idx == REG_BASE_ADDR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width      <= WIDTH_RESET;
			cfg_q.src_height     <= HEIGHT_RESET;
			cfg_q.base_word_addr <= BASE_ADDR_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WIDTH:     cfg_q.src_width      <= pwdata[DIM_W-1:0];
				REG_HEIGHT:    cfg_q.src_height     <= pwdata[DIM_W-1:0];
				REG_BASE_ADDR: cfg_q.base_word_addr <= pwdata[ADDR_W-1:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH:     prdata = PDATA_W'(cfg_q.src_width);
			REG_HEIGHT:    prdata = PDATA_W'(cfg_q.src_height);
			REG_BASE_ADDR: prdata = PDATA_W'(cfg_q.base_word_addr);
			default:       prdata = '0;
		endcase
	end

	ywr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.base_wr   (base_wr),
		.base_new  (pwdata[ADDR_W-1:0]),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	ywr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	ywr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* verif/yuv420_to_packed_422_writer_core_test.sv */
// Self-checking testbench for the planar 4:2:0 to packed 4:2:2 frame writer.
module yuv420_to_packed_422_writer_core_test;
	import ywr_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_GROUPS = 1450;
	localparam int WATCHDOG_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	yuv420_to_packed_422_writer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mirror of the frame geometry and the write position.
	logic [DIM_W-1:0] geo_width = WIDTH_RESET;
	logic [DIM_W-1:0] geo_height = HEIGHT_RESET;
	logic [ADDR_W-1:0] dst_base = BASE_ADDR_RESET;
	logic [COL_W-1:0] pos_col = '0;
	logic [ROW_W-1:0] pos_row = '0;
	logic [ADDR_W-1:0] line_base = BASE_ADDR_RESET;
	logic [2*BYTE_W-1:0] chroma_row [STORE_DEPTH];
	bit chroma_written [STORE_DEPTH];

	in_item_t pending_groups [$];
	out_item_t expected_words [$];
	int queued_count = 0;
	int accepted_count = 0;
	int errors = 0;
	int idle_cycles = 0;
	int in_gap = 0;
	int stall_left = 0;
	bit in_took = 1'b0;
	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;
	bit quiet = 1'b0;

	function automatic int eff_dim(logic [DIM_W-1:0] v, int hi);
		int d;
		d = (v < 2) ? 2 : (v > hi) ? hi : int'(v);
		return d & ~1;
	endfunction

	// Pack one group and advance the raster position.
	function automatic out_item_t pack_group(in_item_t g);
		int w;
		int groups;
		int pitch;
		int line_words;
		logic [BYTE_W-1:0] cr;
		logic [BYTE_W-1:0] cb;
		out_item_t r;
		w = eff_dim(geo_width, MAX_WIDTH);
		groups = w / 2;
		pitch = ((w + PITCH_ALIGN - 1) / PITCH_ALIGN) * PITCH_ALIGN;
		line_words = groups + (pitch - w) / 2;
		if (!pos_row[0]) begin
			cr = g.chroma_red;
			cb = g.chroma_blue;
			chroma_row[pos_col] = {cb, cr};
			chroma_written[pos_col] = 1'b1;
		end else begin
			{cb, cr} = chroma_row[pos_col];
		end
		r.packed_word = {cb, g.luma_second, cr, g.luma_first};
		r.word_addr = line_base + ADDR_W'(pos_col);
		r.frame_end = 1'b0;
		if (int'(pos_col) + 1 >= groups) begin
			pos_col = '0;
			if (int'(pos_row) + 1 >= eff_dim(geo_height, HEIGHT_LIMIT)) begin
				r.frame_end = 1'b1;
				pos_row = '0;
				line_base = dst_base;
			end else begin
				pos_row = pos_row + 1'b1;
				line_base = line_base + ADDR_W'(line_words);
			end
		end else begin
			pos_col = pos_col + 1'b1;
		end
		return r;
	endfunction

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH: geo_width = value[DIM_W-1:0];
			REG_HEIGHT: geo_height = value[DIM_W-1:0];
			REG_BASE_ADDR: begin
				dst_base = value[ADDR_W-1:0];
				if (pos_col == 0 && pos_row == 0)
					line_base = dst_base;
			end
			default: ;
		endcase
	endtask

	task automatic queue_group(input in_item_t g);
		pending_groups.push_back(g);
		queued_count++;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (accepted_count != queued_count || expected_words.size() != 0);
	endtask

	// Request driver: hold the payload until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_groups.size() != 0) begin
				in_data <= pending_groups.pop_front();
				in_valid <= 1'b1;
				if (in_idle_on && !quiet && $urandom_range(0, 5) == 0)
					in_gap = $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (out_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		bit out_took;
		in_took = in_valid && !in_stall;
		out_took = out_valid && !out_stall;
		if (arst_n) begin
			if (in_took) begin
				expected_words.push_back(pack_group(in_data));
				accepted_count++;
			end
			if (out_took) begin
				if (expected_words.size() == 0) begin
					$display("%0t: word with none expected: %h", $time, out_data);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (out_data.packed_word !== want.packed_word) begin
						$display("%0t: packed_word expected %h actual %h",
							$time, want.packed_word, out_data.packed_word);
						errors++;
					end
					if (out_data.word_addr !== want.word_addr) begin
						$display("%0t: word_addr expected %h actual %h",
							$time, want.word_addr, out_data.word_addr);
						errors++;
					end
					if (out_data.frame_end !== want.frame_end) begin
						$display("%0t: frame_end expected %b actual %b",
							$time, want.frame_end, out_data.frame_end);
						errors++;
					end
				end
			end
			if (in_took || out_took)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int wv;
		int hv;
		int gw;
		int gh;
		int n;
		int c;
		int r;
		int random_sent;
		bit fe;
		bit ok;
		logic [31:0] junk;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Odd height drops the last row; the first row wraps the address space.
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		reg_write(REG_WIDTH, 32'd8);
		reg_write(REG_HEIGHT, 32'd3);
		reg_write(REG_BASE_ADDR, 32'h00FF_FFFE);
		queue_group(32'h0000_0000);
		queue_group(32'hFFFF_FFFF);
		queue_group(32'h55AA_55AA);
		queue_group(32'hAA55_AA55);
		repeat (4) queue_group($urandom);
		wait_drained();

		// Width and height below range clamp to one group by two rows.
		reg_write(REG_WIDTH, 32'd1);
		reg_write(REG_HEIGHT, 32'd0);
		reg_write(REG_BASE_ADDR, 32'd0);
		repeat (2) queue_group($urandom);
		wait_drained();

		// Odd width; base moved in mid-frame applies from the next frame.
		reg_write(REG_WIDTH, 32'd7);
		reg_write(REG_HEIGHT, 32'd5);
		repeat (4) queue_group($urandom);
		wait_drained();
		reg_write(REG_BASE_ADDR, 32'h0012_3456);
		repeat (10) queue_group($urandom);
		wait_drained();

		random_sent = 0;
		while (random_sent < RANDOM_GROUPS) begin
			in_idle_on = $urandom_range(0, 2) != 0;
			out_idle_on = $urandom_range(0, 2) != 0;
			if (random_sent > RANDOM_GROUPS * 4 / 5)
				quiet = 1'b1;
			junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
			case ($urandom_range(0, 19))
				0: wv = $urandom_range(0, 1);
				1: wv = $urandom_range(2049, 4095);
				2: wv = 2048;
				3, 4: wv = $urandom_range(65, 2047);
				default: wv = $urandom_range(2, 40);
			endcase
			case ($urandom_range(0, 19))
				0: hv = $urandom_range(0, 1);
				1: hv = $urandom_range(2049, 4095);
				2: hv = 2048;
				3, 4: hv = $urandom_range(9, 100);
				default: hv = $urandom_range(2, 8);
			endcase
			if ($urandom_range(0, 2) != 0) begin
				// On an odd row, widen only over pairs already stored.
				ok = 1'b1;
				if (pos_row[0]) begin
					gw = eff_dim(DIM_W'(wv), MAX_WIDTH) / 2;
					for (c = int'(pos_col); c < ((gw > int'(pos_col) + 1) ? gw : int'(pos_col) + 1); c++)
						if (!chroma_written[c])
							ok = 1'b0;
				end
				if (ok)
					reg_write(REG_WIDTH, (junk & ~32'hFFF) | 32'(wv));
			end
			if ($urandom_range(0, 2) != 0)
				reg_write(REG_HEIGHT, (junk & ~32'hFFF) | 32'(hv));
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: reg_write(REG_BASE_ADDR, (junk & ~32'hFF_FFFF) | $urandom_range(0, 255));
					1: reg_write(REG_BASE_ADDR,
						(junk & ~32'hFF_FFFF) | (32'hFF_FFFF - $urandom_range(0, 255)));
					default: reg_write(REG_BASE_ADDR, $urandom);
				endcase
			end
			gw = eff_dim(geo_width, MAX_WIDTH) / 2;
			gh = eff_dim(geo_height, HEIGHT_LIMIT);
			if (gw * gh <= 150) begin
				if ($urandom_range(0, 1) != 0) begin
					// Run to the end of the current frame, sometimes one more.
					c = int'(pos_col);
					r = int'(pos_row);
					n = 0;
					fe = 1'b0;
					while (!fe) begin
						n++;
						if (c + 1 >= gw) begin
							c = 0;
							if (r + 1 >= gh)
								fe = 1'b1;
							else
								r++;
						end else begin
							c++;
						end
					end
					n += gw * gh * $urandom_range(0, 1);
				end else begin
					n = $urandom_range(1, 2 * gw * gh);
				end
			end else begin
				n = $urandom_range(10, 120);
			end
			if (n > RANDOM_GROUPS - random_sent)
				n = RANDOM_GROUPS - random_sent;
			repeat (n) queue_group($urandom);
			random_sent += n;
			wait_drained();
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
